@@ rtl/cfts_pkg.sv @@
// shared types, constants and tables for the cubemap texel source core
package cfts_pkg;

    localparam int MAX_SRC_WIDTH  = 16384;
    localparam int MAX_SRC_HEIGHT = 8192;
    localparam int MAX_FACE_SIZE  = 4096;
    localparam int CORDIC_STEPS   = 16;
    localparam int DIV_STEPS      = 16;
    localparam int CW             = 20;
    localparam int AW             = 18;
    localparam int GAIN_INV       = 39797;
    localparam int TURN_HALF      = 32768;
    localparam int TURN_QUARTER   = 16384;
    localparam int ONE_Q16        = 65536;

    // configuration register indexes
    localparam logic [2:0] REG_LAYOUT   = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_FACE     = 3'd3;
    localparam logic [2:0] REG_CHANNELS = 3'd4;

    // layout codes
    localparam logic [2:0] MODE_HCROSS = 3'd0;
    localparam logic [2:0] MODE_VCROSS = 3'd1;
    localparam logic [2:0] MODE_ROW    = 3'd2;
    localparam logic [2:0] MODE_COLUMN = 3'd3;
    localparam logic [2:0] MODE_EQUI   = 3'd4;

    // face codes
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [AW-1:0] ang_t;

    typedef struct packed {
        logic        eq;
        logic [2:0]  face;
        logic        oor;
        logic [14:0] gx;
        logic [14:0] gy;
        cval_t       dy;
        ang_t        lon;
    } side_t;

    typedef struct packed {
        logic [2:0] col;
        logic [2:0] row;
        logic       rot;
    } cell_t;

    // fixed cell of each face per grid layout
    function automatic cell_t grid_cell(input logic [2:0] mode, input logic [2:0] face);
        cell_t c;
        c = '{col: 3'd0, row: 3'd0, rot: 1'b0};
        case (mode)
            MODE_ROW:    c.col = face;
            MODE_COLUMN: c.row = face;
            default: begin
                case (face)
                    FACE_PX: c = '{col: 3'd2, row: 3'd1, rot: 1'b0};
                    FACE_NX: c = '{col: 3'd0, row: 3'd1, rot: 1'b0};
                    FACE_PY: c = '{col: 3'd1, row: 3'd0, rot: 1'b0};
                    FACE_NY: c = '{col: 3'd1, row: 3'd2, rot: 1'b0};
                    FACE_PZ: c = '{col: 3'd1, row: 3'd1, rot: 1'b0};
                    default: begin
                        if (mode == MODE_VCROSS) begin
                            c = '{col: 3'd1, row: 3'd3, rot: 1'b1};
                        end else begin
                            c = '{col: 3'd3, row: 3'd1, rot: 1'b0};
                        end
                    end
                endcase
            end
        endcase
        return c;
    endfunction

    // atan(2^-i) in turn units, 65536 per turn
    function automatic ang_t atan_turn(input int i);
        ang_t t;
        case (i)
            0:  t = 18'sd8192;
            1:  t = 18'sd4836;
            2:  t = 18'sd2555;
            3:  t = 18'sd1297;
            4:  t = 18'sd651;
            5:  t = 18'sd326;
            6:  t = 18'sd163;
            7:  t = 18'sd81;
            8:  t = 18'sd41;
            9:  t = 18'sd20;
            10: t = 18'sd10;
            11: t = 18'sd5;
            12: t = 18'sd3;
            13: t = 18'sd1;
            14: t = 18'sd1;
            default: t = 18'sd0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/cfts_div.sv @@
// pipelined restoring divider, two numerators over the face size, one quotient bit per stage
module cfts_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [28:0]     num_a,
    input  logic [28:0]     num_b,
    input  logic            neg_a,
    input  logic            neg_b,
    input  logic [12:0]     fsz,
    input  cfts_pkg::side_t in_side,
    output logic            out_valid,
    output cfts_pkg::cval_t quo_a,
    output cfts_pkg::cval_t quo_b,
    output cfts_pkg::side_t out_side
);
    import cfts_pkg::*;

    logic [28:0]          ra_reg [0:DIV_STEPS-1];
    logic [28:0]          rb_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] qa_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] qb_reg [0:DIV_STEPS-1];
    logic                 na_reg [0:DIV_STEPS-1];
    logic                 nb_reg [0:DIV_STEPS-1];
    side_t                sd_reg [0:DIV_STEPS-1];
    logic                 v_reg  [0:DIV_STEPS-1];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_stage
            logic [28:0]          ra_cur, rb_cur, dv;
            logic [DIV_STEPS-1:0] qa_cur, qb_cur;
            logic                 na_cur, nb_cur, v_cur, ge_a, ge_b;
            side_t                sd_cur;

            if (k == 0) begin : g_first
                assign ra_cur = num_a;
                assign rb_cur = num_b;
                assign qa_cur = '0;
                assign qb_cur = '0;
                assign na_cur = neg_a;
                assign nb_cur = neg_b;
                assign sd_cur = in_side;
                assign v_cur  = in_valid;
            end else begin : g_next
                assign ra_cur = ra_reg[k-1];
                assign rb_cur = rb_reg[k-1];
                assign qa_cur = qa_reg[k-1];
                assign qb_cur = qb_reg[k-1];
                assign na_cur = na_reg[k-1];
                assign nb_cur = nb_reg[k-1];
                assign sd_cur = sd_reg[k-1];
                assign v_cur  = v_reg[k-1];
            end

            // divisor aligned to this quotient bit
            assign dv   = 29'(fsz) << (DIV_STEPS - 1 - k);
            assign ge_a = (ra_cur >= dv);
            assign ge_b = (rb_cur >= dv);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_cur;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    ra_reg[k] <= ge_a ? ra_cur - dv : ra_cur;
                    rb_reg[k] <= ge_b ? rb_cur - dv : rb_cur;
                    qa_reg[k] <= {qa_cur[DIV_STEPS-2:0], ge_a};
                    qb_reg[k] <= {qb_cur[DIV_STEPS-2:0], ge_b};
                    na_reg[k] <= na_cur;
                    nb_reg[k] <= nb_cur;
                    sd_reg[k] <= sd_cur;
                end
            end
        end
    endgenerate

    // signed quotients
    logic signed [CW-1:0] ua, ub;
    assign ua       = $signed({{(CW-DIV_STEPS){1'b0}}, qa_reg[DIV_STEPS-1]});
    assign ub       = $signed({{(CW-DIV_STEPS){1'b0}}, qb_reg[DIV_STEPS-1]});
    assign quo_a    = na_reg[DIV_STEPS-1] ? -ua : ua;
    assign quo_b    = nb_reg[DIV_STEPS-1] ? -ub : ub;
    assign out_side = sd_reg[DIV_STEPS-1];
    assign out_valid = v_reg[DIV_STEPS-1];

endmodule

@@ rtl/cfts_cordic.sv @@
// pipelined cordic vectoring unit: half-plane fold then one rotation per stage
module cfts_cordic (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cfts_pkg::cval_t x_in,
    input  cfts_pkg::cval_t y_in,
    input  cfts_pkg::side_t in_side,
    output logic            out_valid,
    output cfts_pkg::ang_t  ang,
    output cfts_pkg::cval_t mag,
    output cfts_pkg::side_t out_side
);
    import cfts_pkg::*;

    cval_t x_reg  [0:CORDIC_STEPS];
    cval_t y_reg  [0:CORDIC_STEPS];
    ang_t  a_reg  [0:CORDIC_STEPS];
    side_t sd_reg [0:CORDIC_STEPS];
    logic  v_reg  [0:CORDIC_STEPS];

    // fold left half-plane vectors into the right one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= in_side;
            if (x_in < 0) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                a_reg[0] <= (y_in >= 0) ? ang_t'(TURN_HALF) : -ang_t'(TURN_HALF);
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                a_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            cval_t xs, ys;
            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i+1] <= 1'b0;
                end else if (en) begin
                    v_reg[i+1] <= v_reg[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    sd_reg[i+1] <= sd_reg[i];
                    if (y_reg[i] > 0) begin
                        x_reg[i+1] <= x_reg[i] + ys;
                        y_reg[i+1] <= y_reg[i] - xs;
                        a_reg[i+1] <= a_reg[i] + atan_turn(i);
                    end else begin
                        x_reg[i+1] <= x_reg[i] - ys;
                        y_reg[i+1] <= y_reg[i] + xs;
                        a_reg[i+1] <= a_reg[i] - atan_turn(i);
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[CORDIC_STEPS];
    assign ang       = a_reg[CORDIC_STEPS];
    assign mag       = x_reg[CORDIC_STEPS];
    assign out_side  = sd_reg[CORDIC_STEPS];

endmodule

@@ rtl/cubemap_face_texel_source_core.sv @@
// top level: config registers, front end, angle-to-pixel scaling and address stages
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_face, s_texel_x, s_texel_y
//  m_      | out       | m_valid / m_ready  | m_src_x, m_src_y, m_byte_offset, m_out_of_range
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one texel per cycle unless m_ready stalls the output; stages: front register, divider,
// longitude cordic, gain register, latitude cordic, then scaling and address registers
// reset clears valid bits and loads the register defaults; config is always ready
// a stall at m_ holds the whole pipeline in place; s_ready follows it
module cubemap_face_texel_source_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_face,
    input  logic [11:0] s_texel_x,
    input  logic [11:0] s_texel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_src_x,
    output logic [12:0] m_src_y,
    output logic [28:0] m_byte_offset,
    output logic        m_out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cfts_pkg::*;

    // configuration registers
    logic [2:0]  layout_reg;
    logic [14:0] width_reg;
    logic [13:0] height_reg;
    logic [12:0] face_reg;
    logic [2:0]  chan_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= MODE_HCROSS;
            width_reg  <= 15'd1024;
            height_reg <= 14'd768;
            face_reg   <= 13'd256;
            chan_reg   <= 3'd4;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LAYOUT:   layout_reg <= cfg_data[2:0];
                REG_WIDTH:    width_reg  <= cfg_data[14:0];
                REG_HEIGHT:   height_reg <= cfg_data[13:0];
                REG_FACE:     face_reg   <= cfg_data[12:0];
                REG_CHANNELS: chan_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // saturated working sizes
    logic [14:0] w, wm1;
    logic [13:0] h;
    logic [12:0] hm1;
    logic [12:0] fs, fsm1;
    logic [2:0]  ch, mode;

    assign w    = (width_reg == '0) ? 15'd1 :
                  (width_reg > 15'(MAX_SRC_WIDTH)) ? 15'(MAX_SRC_WIDTH) : width_reg;
    assign h    = (height_reg == '0) ? 14'd1 :
                  (height_reg > 14'(MAX_SRC_HEIGHT)) ? 14'(MAX_SRC_HEIGHT) : height_reg;
    assign fs   = (face_reg == '0) ? 13'd1 :
                  (face_reg > 13'(MAX_FACE_SIZE)) ? 13'(MAX_FACE_SIZE) : face_reg;
    assign ch   = (chan_reg == '0) ? 3'd1 : (chan_reg > 3'd4) ? 3'd4 : chan_reg;
    assign mode = (layout_reg > MODE_EQUI) ? MODE_EQUI : layout_reg;
    assign wm1  = w - 15'd1;
    assign hm1  = 13'(h - 14'd1);
    assign fsm1 = fs - 13'd1;

    // global advance: output slot free or being taken
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // front end: clamp texel, grid cell position, divider numerators
    logic [11:0] tx_c, ty_c, lx, ly;
    logic [2:0]  face_c;
    logic        oor;
    cell_t       gpos;
    logic signed [13:0] na, nb;
    logic [11:0] abs_a, abs_b;
    side_t       f_side;

    assign oor    = ({1'b0, s_texel_x} >= fs) || ({1'b0, s_texel_y} >= fs);
    assign tx_c   = ({1'b0, s_texel_x} >= fs) ? fsm1[11:0] : s_texel_x;
    assign ty_c   = ({1'b0, s_texel_y} >= fs) ? fsm1[11:0] : s_texel_y;
    assign face_c = (s_face > FACE_NZ) ? FACE_NZ : s_face;
    assign gpos   = grid_cell(mode, face_c);
    assign lx     = gpos.rot ? fsm1[11:0] - tx_c : tx_c;
    assign ly     = gpos.rot ? fsm1[11:0] - ty_c : ty_c;
    assign na     = $signed({1'b0, tx_c, 1'b1}) - $signed({1'b0, fs});
    assign nb     = $signed({1'b0, fs}) - $signed({1'b0, ty_c, 1'b1});
    assign abs_a  = na[13] ? 12'(-na) : na[11:0];
    assign abs_b  = nb[13] ? 12'(-nb) : nb[11:0];

    always_comb begin
        f_side      = '0;
        f_side.eq   = (mode == MODE_EQUI);
        f_side.face = face_c;
        f_side.oor  = oor;
        f_side.gx   = 15'(gpos.col) * 15'(fs) + 15'(lx);
        f_side.gy   = 15'(gpos.row) * 15'(fs) + 15'(ly);
    end

    logic        f_valid_reg;
    logic [28:0] f_ma_reg, f_mb_reg;
    logic        f_na_reg, f_nb_reg;
    side_t       f_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_ma_reg   <= {1'b0, abs_a, 16'b0} + 29'(fs[12:1]);
            f_mb_reg   <= {1'b0, abs_b, 16'b0} + 29'(fs[12:1]);
            f_na_reg   <= na[13];
            f_nb_reg   <= nb[13];
            f_side_reg <= f_side;
        end
    end

    // face coordinates a and b in signed Q4.16
    logic  d_valid;
    cval_t qa, qb;
    side_t d_side;

    cfts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .num_a     (f_ma_reg),
        .num_b     (f_mb_reg),
        .neg_a     (f_na_reg),
        .neg_b     (f_nb_reg),
        .fsz       (fs),
        .in_side   (f_side_reg),
        .out_valid (d_valid),
        .quo_a     (qa),
        .quo_b     (qb),
        .out_side  (d_side)
    );

    // face direction vector
    cval_t dx, dy, dz;
    side_t c1_side;
    localparam cval_t ONE = cval_t'(ONE_Q16);

    always_comb begin
        case (d_side.face)
            FACE_PX: begin dx = ONE; dy = qb;   dz = -qa;  end
            FACE_NX: begin dx = -ONE; dy = qb;  dz = qa;   end
            FACE_PY: begin dx = qa;  dy = ONE;  dz = -qb;  end
            FACE_NY: begin dx = qa;  dy = -ONE; dz = qb;   end
            FACE_PZ: begin dx = qa;  dy = qb;   dz = ONE;  end
            default: begin dx = -qa; dy = qb;   dz = -ONE; end
        endcase
        c1_side    = d_side;
        c1_side.dy = dy;
    end

    // longitude
    logic  l_valid;
    ang_t  lon;
    cval_t lmag;
    side_t l_side;

    cfts_cordic u_lon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .x_in      (-dz),
        .y_in      (dx),
        .in_side   (c1_side),
        .out_valid (l_valid),
        .ang       (lon),
        .mag       (lmag),
        .out_side  (l_side)
    );

    // cordic gain removal
    logic [35:0] gprod;
    logic        g_valid_reg;
    cval_t       g_r_reg;
    side_t       g_side, g_side_reg;

    assign gprod = 36'(lmag[CW-2:0]) * 36'(GAIN_INV);

    // carry the longitude along with the item
    always_comb begin
        g_side     = l_side;
        g_side.lon = lon;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= l_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_r_reg    <= $signed({1'b0, gprod[16+CW-2:16]});
            g_side_reg <= g_side;
        end
    end

    // latitude
    logic  t_valid;
    ang_t  lat;
    cval_t tmag;
    side_t t_side;

    cfts_cordic u_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_valid_reg),
        .x_in      (g_r_reg),
        .y_in      (g_side_reg.dy),
        .in_side   (g_side_reg),
        .out_valid (t_valid),
        .ang       (lat),
        .mag       (tmag),
        .out_side  (t_side)
    );

    // scale angles to source pixels
    ang_t        nx, ny;
    logic [31:0] px;
    logic [30:0] py;
    logic        p1_valid_reg;
    logic [15:0] p1_x_reg, p1_y_reg;
    side_t       p1_side_reg;

    assign nx = t_side.lon + ang_t'(TURN_HALF);
    assign ny = ang_t'(TURN_QUARTER) - lat;
    assign px = (nx > 0) ? 32'(nx[16:0]) * 32'(w) : '0;
    assign py = (ny > 0) ? 31'(ny[16:0]) * 31'(h) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= t_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_x_reg    <= px[31:16];
            p1_y_reg    <= py[30:15];
            p1_side_reg <= t_side;
        end
    end

    // select mapping and clamp to image
    logic [15:0] ex, ey;
    logic        p2_valid_reg, p2_oor_reg;
    logic [13:0] p2_x_reg;
    logic [12:0] p2_y_reg;

    assign ex = p1_side_reg.eq ? p1_x_reg : {1'b0, p1_side_reg.gx};
    assign ey = p1_side_reg.eq ? p1_y_reg : {1'b0, p1_side_reg.gy};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_x_reg   <= (ex > 16'(wm1)) ? wm1[13:0] : ex[13:0];
            p2_y_reg   <= (ey > 16'(hm1)) ? hm1 : ey[12:0];
            p2_oor_reg <= p1_side_reg.oor;
        end
    end

    // row start
    logic        p3_valid_reg, p3_oor_reg;
    logic [13:0] p3_x_reg;
    logic [12:0] p3_y_reg;
    logic [27:0] p3_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_row_reg <= 28'(p2_y_reg) * 28'(w);
            p3_x_reg   <= p2_x_reg;
            p3_y_reg   <= p2_y_reg;
            p3_oor_reg <= p2_oor_reg;
        end
    end

    // pixel index
    logic        p4_valid_reg, p4_oor_reg;
    logic [13:0] p4_x_reg;
    logic [12:0] p4_y_reg;
    logic [28:0] p4_lin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_lin_reg <= 29'(p3_row_reg) + 29'(p3_x_reg);
            p4_x_reg   <= p3_x_reg;
            p4_y_reg   <= p3_y_reg;
            p4_oor_reg <= p3_oor_reg;
        end
    end

    // output register: byte offset
    logic        o_valid_reg, o_oor_reg;
    logic [13:0] o_x_reg;
    logic [12:0] o_y_reg;
    logic [28:0] o_off_reg;
    logic [31:0] off_full;

    assign off_full = 32'(p4_lin_reg) * 32'(ch);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_off_reg <= off_full[28:0];
            o_x_reg   <= p4_x_reg;
            o_y_reg   <= p4_y_reg;
            o_oor_reg <= p4_oor_reg;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_src_x        = o_x_reg;
    assign m_src_y        = o_y_reg;
    assign m_byte_offset  = o_off_reg;
    assign m_out_of_range = o_oor_reg;

endmodule

@@ tb/sv/cubemap_face_texel_source_core_tb.sv @@
// self-checking testbench for the cubemap face texel source core
module cubemap_face_texel_source_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfts_pkg::*;

    localparam int LATENCY     = 57;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 70;
    localparam int NUM_PHASES  = 13;

    typedef struct packed {
        logic [13:0] sx;
        logic [12:0] sy;
        logic [28:0] offset;
        logic        oor;
    } texel_src_t;

    typedef struct packed {
        logic [2:0]  face;
        logic [11:0] tx;
        logic [11:0] ty;
        logic        typed;
        texel_src_t  want;
    } texel_req_t;

    // grid cell column and row per layout and face
    localparam int CELL_COL [0:3][0:5] = '{'{2,0,1,1,1,3}, '{2,0,1,1,1,1},
                                           '{0,1,2,3,4,5}, '{0,0,0,0,0,0}};
    localparam int CELL_ROW [0:3][0:5] = '{'{1,1,0,2,1,1}, '{1,1,0,2,1,3},
                                           '{0,0,0,0,0,0}, '{0,1,2,3,4,5}};
    localparam int ATAN_TURNS [0:15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                         41, 20, 10, 5, 3, 1, 1, 0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_face = '0;
    logic [11:0] s_texel_x = '0;
    logic [11:0] s_texel_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [13:0] m_src_x;
    logic [12:0] m_src_y;
    logic [28:0] m_byte_offset;
    logic        m_out_of_range;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // shadow copy of the configuration registers
    logic [2:0]  layout_reg   = 3'd0;
    logic [14:0] width_reg    = 15'd1024;
    logic [13:0] height_reg   = 14'd768;
    logic [12:0] face_reg     = 13'd256;
    logic [2:0]  channels_reg = 3'd4;

    texel_req_t texel_q[$];
    texel_src_t src_addr_q[$];
    texel_req_t cur_req;
    int         cycles = 0;
    int         errors = 0;
    logic       calm;

    cubemap_face_texel_source_core uut (.*);

    always #2 aclk = ~aclk;

    // long idle-free stretch in every window of cycles
    assign calm = (cycles % 6000) < 1200;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // n * 65536 / d, nearest with ties away from zero
    function automatic longint q16_div(input longint n, input longint d);
        longint m, q;
        m = (n < 0 ? -n : n) * ONE_Q16;
        q = (m + d / 2) / d;
        return n < 0 ? -q : q;
    endfunction

    // vectoring rotation: angle of (x, y) in turn units, gain-scaled magnitude
    function automatic longint vector_turns(input longint x0, input longint y0,
                                            output longint mag);
        longint x, y, ang, xs, ys;
        x = x0;
        y = y0;
        ang = 0;
        if (x < 0) begin
            ang = (y >= 0) ? TURN_HALF : -TURN_HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                ang += ATAN_TURNS[i];
            end else begin
                x -= ys;
                y += xs;
                ang -= ATAN_TURNS[i];
            end
        end
        mag = x;
        return ang;
    endfunction

    // source texel and byte address for one face texel under the current registers
    function automatic texel_src_t source_texel(input logic [2:0] face_in,
                                                input logic [11:0] tx_in,
                                                input logic [11:0] ty_in);
        longint w, h, fs, ch, f, tx, ty, sx, sy, a, b, dx, dy, dz, mag, r, lon, lat;
        bit [63:0] prod;
        texel_src_t res;
        w  = clamp_range(width_reg, 1, MAX_SRC_WIDTH);
        h  = clamp_range(height_reg, 1, MAX_SRC_HEIGHT);
        fs = clamp_range(face_reg, 1, MAX_FACE_SIZE);
        ch = clamp_range(channels_reg, 1, 4);
        f  = face_in > FACE_NZ ? FACE_NZ : face_in;
        res.oor = (tx_in >= fs) || (ty_in >= fs);
        tx = tx_in >= fs ? fs - 1 : tx_in;
        ty = ty_in >= fs ? fs - 1 : ty_in;
        if (layout_reg < MODE_EQUI) begin
            // rotated -Z cell of the vertical cross
            if (layout_reg == MODE_VCROSS && f == FACE_NZ) begin
                tx = fs - 1 - tx;
                ty = fs - 1 - ty;
            end
            sx = CELL_COL[layout_reg][f] * fs + tx;
            sy = CELL_ROW[layout_reg][f] * fs + ty;
        end else begin
            a = q16_div(2 * tx + 1 - fs, fs);
            b = q16_div(fs - 2 * ty - 1, fs);
            case (f)
                FACE_PX: begin dx = ONE_Q16;  dy = b;        dz = -a;       end
                FACE_NX: begin dx = -ONE_Q16; dy = b;        dz = a;        end
                FACE_PY: begin dx = a;        dy = ONE_Q16;  dz = -b;       end
                FACE_NY: begin dx = a;        dy = -ONE_Q16; dz = b;        end
                FACE_PZ: begin dx = a;        dy = b;        dz = ONE_Q16;  end
                default: begin dx = -a;       dy = b;        dz = -ONE_Q16; end
            endcase
            lon = vector_turns(-dz, dx, mag);
            prod = mag * GAIN_INV;
            r = longint'(prod >> 16);
            lat = vector_turns(r, dy, mag);
            lon = lon + TURN_HALF;
            lat = TURN_QUARTER - lat;
            sx = lon <= 0 ? 0 : (lon * w) >> 16;
            sy = lat <= 0 ? 0 : (lat * h) >> 15;
        end
        if (sx > w - 1) sx = w - 1;
        if (sy > h - 1) sy = h - 1;
        res.sx = sx[13:0];
        res.sy = sy[12:0];
        res.offset = 29'((sy * w + sx) * ch);
        return res;
    endfunction

    // input channel: start transfers, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                src_addr_q.push_back(cur_req.typed ? cur_req.want
                                     : source_texel(s_face, s_texel_x, s_texel_y));
            end
            if (!s_valid || s_ready) begin
                if (texel_q.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
                    cur_req = texel_q.pop_front();
                    s_valid   <= 1'b1;
                    s_face    <= cur_req.face;
                    s_texel_x <= cur_req.tx;
                    s_texel_y <= cur_req.ty;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result channel: random backpressure and field checks
    always @(posedge aclk) begin
        texel_src_t want;
        m_ready <= calm || ($urandom_range(0, 99) >= 27);
        if (aresetn && m_valid && m_ready) begin
            if (src_addr_q.size() == 0) begin
                $display("%0t unexpected transfer: src_x %0d src_y %0d", $realtime,
                         m_src_x, m_src_y);
                errors++;
            end else begin
                want = src_addr_q.pop_front();
                if (m_src_x !== want.sx) begin
                    $display("%0t src_x expected %0d actual %0d", $realtime, want.sx, m_src_x);
                    errors++;
                end
                if (m_src_y !== want.sy) begin
                    $display("%0t src_y expected %0d actual %0d", $realtime, want.sy, m_src_y);
                    errors++;
                end
                if (m_byte_offset !== want.offset) begin
                    $display("%0t byte_offset expected %0d actual %0d", $realtime,
                             want.offset, m_byte_offset);
                    errors++;
                end
                if (m_out_of_range !== want.oor) begin
                    $display("%0t out_of_range expected %0d actual %0d", $realtime,
                             want.oor, m_out_of_range);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LAYOUT:   layout_reg   = value[2:0];
            REG_WIDTH:    width_reg    = value[14:0];
            REG_HEIGHT:   height_reg   = value[13:0];
            REG_FACE:     face_reg     = value[12:0];
            REG_CHANNELS: channels_reg = value[2:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] mode, input logic [15:0] w,
                             input logic [15:0] h, input logic [15:0] fs,
                             input logic [15:0] ch);
        write_reg(REG_LAYOUT, mode);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_FACE, fs);
        write_reg(REG_CHANNELS, ch);
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (texel_q.size() > 0 || s_valid || src_addr_q.size() > 0);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    function automatic texel_req_t mk(input logic [2:0] f, input logic [11:0] x,
                                      input logic [11:0] y);
        texel_req_t t;
        t = '0;
        t.face = f;
        t.tx = x;
        t.ty = y;
        return t;
    endfunction

    function automatic texel_req_t mk_typed(input logic [2:0] f, input logic [11:0] x,
                                            input logic [11:0] y, input int sx, input int sy,
                                            input int off, input logic oor);
        texel_req_t t;
        t = mk(f, x, y);
        t.typed = 1'b1;
        t.want = '{sx: sx[13:0], sy: sy[12:0], offset: off[28:0], oor: oor};
        return t;
    endfunction

    // directed rows under the reset configuration
    texel_req_t dir_rows [0:11];

    initial begin
        logic [15:0] ph [0:NUM_PHASES-1][0:4];
        int          lim;

        dir_rows[0]  = mk_typed(FACE_PX, 12'd0, 12'd0, 512, 256, 1050624, 1'b0);
        dir_rows[1]  = mk_typed(FACE_NX, 12'd255, 12'd255, 255, 511, 2094076, 1'b0);
        dir_rows[2]  = mk_typed(FACE_NZ, 12'd4095, 12'd4095, 1023, 511, 2097148, 1'b1);
        dir_rows[3]  = mk_typed(3'd7, 12'd0, 12'd0, 768, 256, 1051648, 1'b0);
        dir_rows[4]  = mk(FACE_PY, 12'd128, 12'd64);
        dir_rows[5]  = mk(FACE_NY, 12'd4095, 12'd0);
        dir_rows[6]  = mk(FACE_PZ, 12'd0, 12'd4095);
        dir_rows[7]  = mk(3'd6, 12'd255, 12'd0);
        dir_rows[8]  = mk(FACE_PZ, 12'd256, 12'd255);
        dir_rows[9]  = mk(FACE_PX, 12'hAAA, 12'h555);
        dir_rows[10] = mk(FACE_NX, 12'h555, 12'hAAA);
        dir_rows[11] = mk(FACE_NY, 12'd17, 12'd200);

        // mode, width, height, face size, channels; extremes first
        ph[0]  = '{MODE_VCROSS, 16'd768, 16'd1024, 16'd256, 16'd3};
        ph[1]  = '{MODE_ROW, 16'd16384, 16'hFFFF, 16'd4096, 16'd4};
        ph[2]  = '{MODE_COLUMN, 16'd1, 16'd1, 16'd1, 16'd1};
        ph[3]  = '{MODE_EQUI, 16'd2048, 16'd1024, 16'd512, 16'd4};
        ph[4]  = '{MODE_EQUI, 16'd0, 16'd0, 16'd0, 16'd0};
        ph[5]  = '{16'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd7};
        ph[6]  = '{16'd7, 16'd640, 16'd320, 16'd64, 16'd2};
        ph[7]  = '{MODE_HCROSS, 16'd64, 16'd48, 16'd16, 16'd5};
        ph[8]  = '{16'd6, 16'd16384, 16'd8192, 16'd4095, 16'd3};
        for (int p = 9; p < NUM_PHASES; p++) begin
            ph[p] = '{16'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                      16'($urandom_range(1, 700)), 16'($urandom_range(0, 7))};
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) texel_q.push_back(dir_rows[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_all(ph[p][0], ph[p][1], ph[p][2], ph[p][3], ph[p][4]);
            lim = clamp_range(face_reg, 1, MAX_FACE_SIZE);
            // mostly in-face texels, some anywhere in the field range
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 80) begin
                    texel_q.push_back(mk(3'($urandom_range(0, 5)),
                                         12'($urandom_range(0, lim - 1)),
                                         12'($urandom_range(0, lim - 1))));
                end else begin
                    texel_q.push_back(mk(3'($urandom), 12'($urandom), 12'($urandom)));
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cfts_pkg.sv
rtl/cfts_div.sv
rtl/cfts_cordic.sv
rtl/cubemap_face_texel_source_core.sv
tb/sv/cubemap_face_texel_source_core_tb.sv
